// ----- sv/dsil_pkg.sv -----
// shared types and constants for the depth sorted insert list
package dsil_pkg;

  localparam int HANDLE_W    = 16;
  localparam int COORD_W     = 17;
  localparam int KEY_W       = 38;
  localparam int DIFF_W      = 20;
  localparam int MAG_W       = 19;
  localparam int ACC_W       = 40;
  localparam int CAP_W       = 6;
  localparam int IN_TDATA_W  = 176;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;

  localparam logic [KEY_W-1:0] KEY_ALL_ONES = {KEY_W{1'b1}};
  localparam logic [CAP_W-1:0] CAP_RESET    = 6'd32;

  localparam logic [1:0] CMD_SORTED = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_DRAIN  = 2'd2;

  localparam logic [1:0] REG_VIEW_X   = 2'd0;
  localparam logic [1:0] REG_VIEW_Y   = 2'd1;
  localparam logic [1:0] REG_VIEW_Z   = 2'd2;
  localparam logic [1:0] REG_CAPACITY = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [KEY_W-1:0]          key_t;

  typedef struct packed {
    coord_t view;
    coord_t bmin;
    coord_t bmax;
    coord_t place;
  } axis_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    key_t                key;
  } entry_t;

  typedef enum logic [1:0] {
    ST_DRAINED = 2'd0,
    ST_ADDED   = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_KEY,
    S_CHK,
    S_INS_RD,
    S_INS_CMP,
    S_RESP,
    S_DRN_RD,
    S_DRN_OUT
  } state_t;

endpackage

// ----- sv/dsil_key_unit.sv -----
// distance key unit: one shared squarer stepped over the three axes
module dsil_key_unit import dsil_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  axis_t [2:0]     axes,
  output logic            done,
  output key_t            key
);

  localparam logic [2:0] LAST_AXIS = 3'd2;
  localparam logic [2:0] FIRST_MUL = 3'd1;
  localparam logic [2:0] LAST_MUL  = 3'd3;
  localparam logic [2:0] FIRST_ACC = 3'd2;
  localparam logic [2:0] LAST_STEP = 3'd4;

  logic                   busy_r;
  logic                   done_r;
  logic [2:0]             step_r;
  logic [MAG_W-1:0]       mag_r;
  logic [2*MAG_W-1:0]     prod_r;
  logic [ACC_W-1:0]       acc_r;

  axis_t                  sel;
  logic signed [DIFF_W-1:0] twice_view;
  logic signed [DIFF_W-1:0] center;
  logic signed [DIFF_W-1:0] diff;
  logic [MAG_W-1:0]       mag_nxt;

  always_comb begin
    unique case (step_r[1:0])
      2'd0:    sel = axes[0];
      2'd1:    sel = axes[1];
      default: sel = axes[2];
    endcase
  end

  always_comb begin
    twice_view = DIFF_W'(sel.view) <<< 1;
    center     = DIFF_W'(sel.bmin) + DIFF_W'(sel.bmax) + (DIFF_W'(sel.place) <<< 1);
    diff       = twice_view - center;
    mag_nxt    = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
    end else if (busy_r) begin
      if (step_r <= LAST_AXIS) begin
        mag_r <= mag_nxt;
      end
      if (step_r >= FIRST_MUL && step_r <= LAST_MUL) begin
        prod_r <= mag_r * mag_r;
      end
      if (step_r >= FIRST_ACC) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
  end

  assign done = done_r;
  assign key  = (acc_r > ACC_W'(KEY_ALL_ONES)) ? KEY_ALL_ONES : acc_r[KEY_W-1:0];

endmodule

// ----- sv/dsil_list_mem.sv -----
// list storage: one write port and one registered read port
module dsil_list_mem import dsil_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int IDX_W = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/depth_sorted_insert_list.sv -----
// top level: sorted object list with distance keys, stream ports and apb registers
// steps: an add computes its key (a far sorted add skips it) and checks the capacity; a sorted
//   add then moves each entry of smaller key down one place; a drain sends each entry in turn
// throughput: one item at a time, the next accepted only after its last result loads;
//   one squarer over three axis steps, each moved entry a read and a write of the list memory
// reset clears the entry count and view registers, sets capacity to 32; list contents are not cleared
module depth_sorted_insert_list import dsil_pkg::*; #(
  parameter int MAX_ENTRIES = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // object_handle, far_flag, box_min_x/y/z, box_max_x/y/z, place_x/y/z, zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // command
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_handle, out_key, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // status
  output logic [1:0]             out_tuser,
  output logic                   out_tlast,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_AW-1:0]      cfg_paddr,
  input  logic [CFG_DW-1:0]      cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r;
  logic [IDX_W-1:0]        ptr_r;
  key_t                    key_r;
  status_t                 resp_st_r;
  logic [1:0]              cmd_r;
  logic [IN_TDATA_W-1:0]   item_r;

  coord_t                  view_x_r, view_y_r, view_z_r;
  logic [CAP_W-1:0]        cap_r;

  logic                    out_valid_r;
  logic [HANDLE_W-1:0]     out_handle_r;
  key_t                    out_key_r;
  status_t                 out_status_r;
  logic                    out_last_r;

  logic                    in_fire;
  logic                    out_free;
  logic                    cfg_wr;
  logic                    need_key;
  logic                    key_start;
  logic                    key_done;
  key_t                    key_out;
  axis_t [2:0]             axes;
  logic                    full;
  logic                    drain_last;
  logic                    place_now;
  logic                    move_down;
  logic                    out_load;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_raddr;
  entry_t                  mem_wdata;
  entry_t                  mem_rdata;
  entry_t                  new_entry;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign need_key  = !((in_tuser == CMD_SORTED) && in_tdata[16]);

  always_comb begin
    axes[0] = '{view: view_x_r, bmin: coord_t'(item_r[33:17]),
                bmax: coord_t'(item_r[84:68]), place: coord_t'(item_r[135:119])};
    axes[1] = '{view: view_y_r, bmin: coord_t'(item_r[50:34]),
                bmax: coord_t'(item_r[101:85]), place: coord_t'(item_r[152:136])};
    axes[2] = '{view: view_z_r, bmin: coord_t'(item_r[67:51]),
                bmax: coord_t'(item_r[118:102]), place: coord_t'(item_r[169:153])};
  end

  assign full = (CMP_W'(count_r) >= CMP_W'(cap_r)) ||
                (CMP_W'(count_r) >= CMP_W'(MAX_ENTRIES));
  assign drain_last = ((CNT_W'(ptr_r) + CNT_W'(1)) == count_r);
  assign move_down  = (mem_rdata.key < key_r);
  assign new_entry  = '{handle: item_r[15:0], key: key_r};

  dsil_key_unit u_key (
    .clk   (clk),
    .rst_n (rst_n),
    .start (key_start),
    .axes  (axes),
    .done  (key_done),
    .key   (key_out)
  );

  dsil_list_mem #(
    .DEPTH (MAX_ENTRIES),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ptr_r),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_tuser == CMD_SORTED || in_tuser == CMD_APPEND) begin
            state_nxt = need_key ? S_KEY : S_CHK;
          end else if (in_tuser == CMD_DRAIN) begin
            state_nxt = (count_r == '0) ? S_RESP : S_DRN_RD;
          end
        end
      end
      S_KEY: begin
        if (key_done) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK:     state_nxt = full ? S_RESP : S_INS_RD;
      S_INS_RD:  state_nxt = place_now ? S_RESP : S_INS_CMP;
      S_INS_CMP: state_nxt = move_down ? S_INS_RD : S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_DRN_RD:  state_nxt = S_DRN_OUT;
      S_DRN_OUT: begin
        if (out_free) begin
          state_nxt = drain_last ? S_IDLE : S_DRN_RD;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    key_start = in_fire && need_key &&
                (in_tuser == CMD_SORTED || in_tuser == CMD_APPEND);
    place_now = (ptr_r == '0) || (cmd_r == CMD_APPEND);
    mem_we    = 1'b0;
    mem_wdata = new_entry;
    mem_raddr = ptr_r;
    out_load  = 1'b0;
    unique case (state_r)
      S_INS_RD: begin
        mem_raddr = ptr_r - IDX_W'(1);
        mem_we    = place_now;
      end
      S_INS_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = move_down ? mem_rdata : new_entry;
      end
      S_RESP, S_DRN_OUT: out_load = out_free;
      default: ;
    endcase
  end

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_VIEW_X:   cfg_prdata = CFG_DW'(unsigned'(view_x_r));
      REG_VIEW_Y:   cfg_prdata = CFG_DW'(unsigned'(view_y_r));
      REG_VIEW_Z:   cfg_prdata = CFG_DW'(unsigned'(view_z_r));
      REG_CAPACITY: cfg_prdata = CFG_DW'(cap_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      view_x_r    <= '0;
      view_y_r    <= '0;
      view_z_r    <= '0;
      cap_r       <= CAP_RESET;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_INS_RD && place_now) || (state_r == S_INS_CMP && !move_down)) begin
        count_r <= count_r + CNT_W'(1);
      end else if (state_r == S_DRN_OUT && out_load && drain_last) begin
        count_r <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (cfg_paddr[3:2])
          REG_VIEW_X:   view_x_r <= coord_t'(cfg_pwdata[COORD_W-1:0]);
          REG_VIEW_Y:   view_y_r <= coord_t'(cfg_pwdata[COORD_W-1:0]);
          REG_VIEW_Z:   view_z_r <= coord_t'(cfg_pwdata[COORD_W-1:0]);
          REG_CAPACITY: cap_r    <= cfg_pwdata[CAP_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r    <= in_tdata;
      cmd_r     <= in_tuser;
      key_r     <= KEY_ALL_ONES;
      ptr_r     <= '0;
      resp_st_r <= ST_EMPTY;
    end
    unique case (state_r)
      S_KEY: begin
        if (key_done) begin
          key_r <= key_out;
        end
      end
      S_CHK: begin
        ptr_r     <= count_r[IDX_W-1:0];
        resp_st_r <= full ? ST_FULL : ST_ADDED;
      end
      S_INS_CMP: begin
        if (move_down) begin
          ptr_r <= ptr_r - IDX_W'(1);
        end
      end
      S_DRN_OUT: begin
        if (out_load && !drain_last) begin
          ptr_r <= ptr_r + IDX_W'(1);
        end
      end
      default: ;
    endcase
    if (out_load) begin
      if (state_r == S_DRN_OUT) begin
        out_handle_r <= mem_rdata.handle;
        out_key_r    <= mem_rdata.key;
        out_status_r <= ST_DRAINED;
        out_last_r   <= drain_last;
      end else begin
        out_handle_r <= (resp_st_r == ST_EMPTY) ? '0 : item_r[15:0];
        out_key_r    <= (resp_st_r == ST_EMPTY) ? '0 : key_r;
        out_status_r <= resp_st_r;
        out_last_r   <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - HANDLE_W - KEY_W)'(0), out_key_r, out_handle_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above list depth");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_INS_RD || state_r == S_INS_CMP))
    else $error("list written outside insertion");

  a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRN_OUT && out_load && drain_last) |=> (count_r == '0))
    else $error("list not empty after drain");

  a_key_done: assert property (@(posedge clk) disable iff (!rst_n)
    key_done |-> (state_r == S_KEY))
    else $error("key finished while not waiting for it");
`endif

endmodule

// ----- bench/testbench.sv -----
// self-checking bench for the depth sorted insert list: predicts every result and checks the stream
module testbench import dsil_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH = 32;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 100;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [15:0]       handle;
    logic              far_on;
    logic [2:0][16:0]  place;
    logic [2:0][16:0]  bmax;
    logic [2:0][16:0]  bmin;
  } list_cmd_t;

  typedef struct packed {
    logic [15:0] handle;
    key_t        key;
    status_t     status;
    logic        last;
  } list_out_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // object_handle, far_flag, box_min_x/y/z, box_max_x/y/z, place_x/y/z, zero pad
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  // command
  logic [1:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // out_handle, out_key, zero pad
  logic [OUT_TDATA_W-1:0] out_tdata;
  // status
  logic [1:0]             out_tuser;
  logic                   out_tlast;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]      cfg_paddr = '0;
  logic [CFG_DW-1:0]      cfg_pwdata = '0;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  depth_sorted_insert_list #(.MAX_ENTRIES(LIST_DEPTH)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // predicted list state and registers
  logic [2:0][16:0] view_pos = '0;
  logic [5:0]       list_cap = CAP_RESET;
  logic [15:0]      shadow_handles [LIST_DEPTH];
  key_t             shadow_keys [LIST_DEPTH];
  int               shadow_count = 0;

  list_cmd_t object_cmds[$];
  list_out_t list_outputs_due[$];
  list_cmd_t cur_cmd;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_len = 0;
  logic hold_go = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0;

  int items_accepted = 0;
  int results_checked = 0;
  int mismatches = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint axis_sq(logic [16:0] v, logic [16:0] lo, logic [16:0] hi,
                                     logic [16:0] pl);
    longint d;
    d = 2 * longint'(coord_t'(v))
        - (longint'(coord_t'(lo)) + longint'(coord_t'(hi)) + 2 * longint'(coord_t'(pl)));
    return d * d;
  endfunction

  function automatic list_out_t outcome(logic [15:0] h, key_t k, status_t st, logic l);
    list_out_t o;
    o.handle = h;
    o.key = k;
    o.status = st;
    o.last = l;
    return o;
  endfunction

  task automatic list_step(input list_cmd_t c);
    longint s;
    key_t k;
    int i;
    int cap;
    case (c.cmd)
      CMD_SORTED, CMD_APPEND: begin
        s = 0;
        for (int a = 0; a < 3; a++) s += axis_sq(view_pos[a], c.bmin[a], c.bmax[a], c.place[a]);
        k = (s > longint'(KEY_ALL_ONES)) ? KEY_ALL_ONES : key_t'(s);
        if (c.cmd == CMD_SORTED && c.far_on) k = KEY_ALL_ONES;
        cap = (list_cap > LIST_DEPTH) ? LIST_DEPTH : int'(list_cap);
        if (shadow_count >= cap) begin
          list_outputs_due.push_back(outcome(c.handle, k, ST_FULL, 1'b1));
        end else begin
          i = shadow_count;
          if (c.cmd == CMD_SORTED) begin
            while (i > 0 && shadow_keys[i-1] < k) begin
              shadow_handles[i] = shadow_handles[i-1];
              shadow_keys[i] = shadow_keys[i-1];
              i--;
            end
          end
          shadow_handles[i] = c.handle;
          shadow_keys[i] = k;
          shadow_count++;
          list_outputs_due.push_back(outcome(c.handle, k, ST_ADDED, 1'b1));
        end
      end
      CMD_DRAIN: begin
        if (shadow_count == 0) begin
          list_outputs_due.push_back(outcome('0, '0, ST_EMPTY, 1'b1));
        end else begin
          for (int e = 0; e < shadow_count; e++)
            list_outputs_due.push_back(outcome(shadow_handles[e], shadow_keys[e], ST_DRAINED,
                                               e == shadow_count - 1));
          shadow_count = 0;
        end
      end
      default: begin
      end
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        list_step(cur_cmd);
        items_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (object_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_cmd = object_cmds.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {6'b0, cur_cmd.place, cur_cmd.bmax, cur_cmd.bmin, cur_cmd.far_on,
                       cur_cmd.handle};
          in_tuser <= cur_cmd.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= hold_len;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    list_out_t got;
    list_out_t exp;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = outcome(out_tdata[15:0], out_tdata[53:16], status_t'(out_tuser), out_tlast);
        results_checked++;
        if (list_outputs_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transfer: handle %h key %h status %0d last %b",
                     got.handle, got.key, got.status, got.last);
        end else begin
          exp = list_outputs_due.pop_front();
          if (got.handle !== exp.handle || got.key !== exp.key ||
              got.status !== exp.status || got.last !== exp.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp handle %h key %h status %0d last %b, got %h %h %0d %b",
                       exp.handle, exp.key, exp.status, exp.last,
                       got.handle, got.key, got.status, got.last);
          end
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic list_cmd_t make_cmd(logic [1:0] cmd, logic [15:0] h, logic far_on,
                                         int lo, int hi, int pl);
    list_cmd_t c;
    c.cmd = cmd;
    c.handle = h;
    c.far_on = far_on;
    for (int a = 0; a < 3; a++) begin
      c.bmin[a] = lo[16:0];
      c.bmax[a] = hi[16:0];
      c.place[a] = pl[16:0];
    end
    return c;
  endfunction

  function automatic logic [16:0] rand_coord();
    int v;
    case ($urandom_range(9))
      0: v = -65536;
      1: v = 65535;
      2: v = 0;
      3, 4: v = int'($urandom_range(4)) - 2;
      5: v = int'($urandom_range(64)) - 32;
      default: v = int'($urandom);
    endcase
    return v[16:0];
  endfunction

  function automatic list_cmd_t rand_cmd(logic [1:0] cmd);
    list_cmd_t c;
    c.cmd = cmd;
    c.handle = 16'($urandom);
    c.far_on = ($urandom_range(3) == 0);
    for (int a = 0; a < 3; a++) begin
      c.bmin[a] = rand_coord();
      c.bmax[a] = rand_coord();
      c.place[a] = rand_coord();
    end
    return c;
  endfunction

  // bursts of adds closed by a drain, with some unused codes and early drains mixed in
  task automatic queue_random(input int target);
    int counted;
    int n;
    int r;
    counted = 0;
    while (counted < target) begin
      n = ($urandom_range(9) == 0) ? int'($urandom_range(36, 20)) : int'($urandom_range(8, 1));
      for (int j = 0; j < n; j++) begin
        r = $urandom_range(99);
        if (r < 60) object_cmds.push_back(rand_cmd(CMD_SORTED));
        else if (r < 90) object_cmds.push_back(rand_cmd(CMD_APPEND));
        else if (r < 95) object_cmds.push_back(rand_cmd(CMD_UNUSED));
        else object_cmds.push_back(rand_cmd(CMD_DRAIN));
        if (r < 95 && r >= 90) continue;
        counted++;
      end
      object_cmds.push_back(rand_cmd(CMD_DRAIN));
      counted++;
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input int value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_AW'({idx, 2'b00});
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_VIEW_X: view_pos[0] = value[16:0];
      REG_VIEW_Y: view_pos[1] = value[16:0];
      REG_VIEW_Z: view_pos[2] = value[16:0];
      REG_CAPACITY: list_cap = value[5:0];
      default: begin
      end
    endcase
  endtask

  task automatic set_view(input int x, input int y, input int z);
    cfg_write(REG_VIEW_X, x);
    cfg_write(REG_VIEW_Y, y);
    cfg_write(REG_VIEW_Z, z);
  endtask

  task automatic start_phase(input int send_pct, input int stall_pct);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  task automatic settle();
    while (object_cmds.size() > 0 || in_tvalid || list_outputs_due.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // default registers: empty drain, extremes, far on sorted and append, equal keys
    start_phase(0, 0);
    object_cmds.push_back(make_cmd(CMD_DRAIN, 16'h0000, 1'b0, 0, 0, 0));
    object_cmds.push_back(make_cmd(CMD_SORTED, 16'h0001, 1'b0, -65536, -65536, -65536));
    object_cmds.push_back(make_cmd(CMD_SORTED, 16'hFFFF, 1'b1, 0, 0, 0));
    object_cmds.push_back(make_cmd(CMD_APPEND, 16'h0000, 1'b1, 65535, 65535, 65535));
    object_cmds.push_back(make_cmd(CMD_SORTED, 16'h0002, 1'b0, -65536, -65536, -65536));
    object_cmds.push_back(make_cmd(CMD_SORTED, 16'h0003, 1'b0, 0, 0, 0));
    object_cmds.push_back(make_cmd(CMD_SORTED, 16'h0004, 1'b0, 65535, 65535, 65535));
    object_cmds.push_back(make_cmd(CMD_UNUSED, 16'hA5A5, 1'b1, 65535, -65536, 0));
    object_cmds.push_back(make_cmd(CMD_APPEND, 16'h0005, 1'b0, 0, 0, 0));
    object_cmds.push_back(make_cmd(CMD_DRAIN, 16'h0000, 1'b0, 0, 0, 0));
    object_cmds.push_back(make_cmd(CMD_DRAIN, 16'hFFFF, 1'b1, 0, 0, 0));
    settle();

    set_view(int'($urandom_range(2000)) - 1000, int'($urandom), 12);
    cfg_write(REG_CAPACITY, 32);
    start_phase(0, 0);
    queue_random(30);
    settle();

    set_view(int'($urandom), int'($urandom), int'($urandom));
    cfg_write(REG_CAPACITY, 5);
    start_phase(69, 0);
    queue_random(30);
    settle();

    // key saturation with the view at the far corner
    set_view(65535, 65535, 65535);
    cfg_write(REG_CAPACITY, 63);
    start_phase(0, 69);
    object_cmds.push_back(make_cmd(CMD_SORTED, 16'h0010, 1'b0, -65536, -65536, -65536));
    object_cmds.push_back(make_cmd(CMD_APPEND, 16'h0011, 1'b0, -65536, -65536, -65536));
    object_cmds.push_back(make_cmd(CMD_SORTED, 16'h0012, 1'b0, 65535, 65535, 65535));
    object_cmds.push_back(make_cmd(CMD_DRAIN, 16'h0000, 1'b0, 0, 0, 0));
    queue_random(30);
    settle();

    // single entry list
    set_view(-65536, 0, 65535);
    cfg_write(REG_CAPACITY, 1);
    start_phase(10, 10);
    object_cmds.push_back(make_cmd(CMD_SORTED, 16'h0020, 1'b0, 100, 200, -50));
    object_cmds.push_back(make_cmd(CMD_SORTED, 16'h0021, 1'b0, 0, 0, 0));
    object_cmds.push_back(make_cmd(CMD_APPEND, 16'h0022, 1'b0, 5, 5, 5));
    object_cmds.push_back(make_cmd(CMD_SORTED, 16'h0023, 1'b1, 0, 0, 0));
    object_cmds.push_back(make_cmd(CMD_DRAIN, 16'h0000, 1'b0, 0, 0, 0));
    object_cmds.push_back(make_cmd(CMD_DRAIN, 16'h0000, 1'b0, 0, 0, 0));
    queue_random(30);
    settle();

    // receiver holds off while a full list and a refused add pile up
    set_view(int'($urandom), int'($urandom), int'($urandom));
    cfg_write(REG_CAPACITY, 32);
    start_phase(0, 0);
    hold_len = 300;
    hold_go <= ~hold_go;
    for (int j = 0; j < LIST_DEPTH + 1; j++) object_cmds.push_back(rand_cmd(CMD_SORTED));
    object_cmds.push_back(rand_cmd(CMD_DRAIN));
    settle();

    // zero capacity refuses every add
    set_view(-65536, -65536, -65536);
    cfg_write(REG_CAPACITY, 0);
    start_phase(10, 10);
    object_cmds.push_back(make_cmd(CMD_SORTED, 16'h0030, 1'b0, 1, 2, 3));
    object_cmds.push_back(make_cmd(CMD_APPEND, 16'h0031, 1'b1, -1, -2, -3));
    object_cmds.push_back(make_cmd(CMD_SORTED, 16'h0032, 1'b1, 0, 0, 0));
    object_cmds.push_back(make_cmd(CMD_DRAIN, 16'h0000, 1'b0, 0, 0, 0));
    queue_random(20);
    settle();

    mismatches += list_outputs_due.size();
    $display("run covered %0d accepted items and %0d checked result transfers, %0d mismatches",
             items_accepted, results_checked, mismatches);
    $display("sorted, append, drain and unused codes; capacities 0 to 63; saturated keys; stalls");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- depth_sorted_insert_list.f -----
sv/dsil_pkg.sv
sv/dsil_key_unit.sv
sv/dsil_list_mem.sv
sv/depth_sorted_insert_list.sv
bench/testbench.sv
